// ----- rtl/srec_pkg.sv -----
// ----------------------------------------------------------------------------
// srec_pkg: shared types and constants for the S-record loader
// State encoding, result kinds, ASCII codes, and the control/status bundles
// that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package srec_pkg;

    localparam int MAX_RECORD_CHARS_DEF = 80;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic CFG_BASE_ADDRESS   = 1'b0;
    localparam logic CFG_MIN_BYTE_COUNT = 1'b1;

    localparam logic [7:0] CH_S  = 8'h53;
    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_1  = 8'h31;
    localparam logic [7:0] CH_2  = 8'h32;
    localparam logic [7:0] CH_3  = 8'h33;
    localparam logic [7:0] CH_4  = 8'h34;
    localparam logic [7:0] CH_7  = 8'h37;
    localparam logic [7:0] CH_8  = 8'h38;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_A  = 8'h41;
    localparam logic [7:0] CH_F  = 8'h46;

    typedef enum logic [2:0] {
        ST_START,
        ST_BYPASS,
        ST_TYPE,
        ST_COUNT,
        ST_BODY,
        ST_EMIT_RD,
        ST_EMIT_WR,
        ST_HALT
    } ctl_state_t;

    typedef struct packed {
        logic rec_start;
        logic load_type;
        logic count_char;
        logic body_char;
        logic start_emit;
        logic emit_step;
        logic out_err;
        logic out_start;
        logic out_data;
    } srec_cmd_t;

    typedef struct packed {
        logic c_is_s;
        logic c_is_nl;
        logic c_is_digit;
        logic c_is_4;
        logic c_is_hex;
        logic second_digit;
        logic cnt_bad;
        logic full;
        logic done;
        logic sum_ok;
        logic is_data;
        logic is_start;
        logic ndata_zero;
        logic emit_last;
        logic slot_free;
    } srec_sts_t;

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CH_0 && c <= CH_9) d = c - CH_0;
        else if (c >= CH_A && c <= CH_F) d = c - CH_A + 8'd10;
        return d[3:0];
    endfunction

    // Address width in bytes by record type character.
    function automatic logic [2:0] addr_bytes(input logic [7:0] t);
        logic [2:0] n;
        n = 3'd0;
        if (t == CH_1 || t == CH_9) n = 3'd2;
        else if (t == CH_2 || t == CH_8) n = 3'd3;
        else if (t == CH_3 || t == CH_7) n = 3'd4;
        return n;
    endfunction

endpackage

// ----- rtl/srec_ctrl.sv -----
// ----------------------------------------------------------------------------
// srec_ctrl: record parser sequencer
// Walks line/type/count/body phases, then steps the byte write-out.
// ----------------------------------------------------------------------------
module srec_ctrl
    import srec_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  srec_sts_t  sts,
    output srec_cmd_t  cmd,
    output ctl_state_t state
);

    ctl_state_t state_reg, state_next;
    logic       acc;

    assign state = state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_START;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        acc        = 1'b0;
        unique case (state_reg)
            ST_START, ST_BYPASS, ST_TYPE, ST_COUNT, ST_BODY: begin
                s_ready = sts.slot_free;
            end
            ST_HALT: begin
                s_ready = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
        acc = s_valid && s_ready;

        unique case (state_reg)
            ST_START: begin
                if (acc) begin
                    if (sts.c_is_s) begin
                        cmd.rec_start = 1'b1;
                        state_next    = ST_TYPE;
                    end else if (!sts.c_is_nl) begin
                        state_next = ST_BYPASS;
                    end
                end
            end
            ST_BYPASS: begin
                if (acc && sts.c_is_nl) state_next = ST_START;
            end
            ST_TYPE: begin
                if (acc) begin
                    if (!sts.c_is_digit) begin
                        cmd.out_err = 1'b1;
                        state_next  = ST_HALT;
                    end else begin
                        cmd.load_type = 1'b1;
                        state_next    = sts.c_is_4 ? ST_BYPASS : ST_COUNT;
                    end
                end
            end
            ST_COUNT: begin
                if (acc) begin
                    if (!sts.c_is_hex || (sts.second_digit && sts.cnt_bad)) begin
                        cmd.out_err = 1'b1;
                        state_next  = ST_HALT;
                    end else begin
                        cmd.count_char = 1'b1;
                        if (sts.second_digit) state_next = ST_BODY;
                    end
                end
            end
            ST_BODY: begin
                if (acc) begin
                    if (!sts.c_is_hex || sts.full || (sts.done && !sts.sum_ok)) begin
                        cmd.out_err = 1'b1;
                        state_next  = ST_HALT;
                    end else begin
                        cmd.body_char = 1'b1;
                        if (sts.done) begin
                            state_next = ST_BYPASS;
                            if (sts.is_data && !sts.ndata_zero) begin
                                cmd.start_emit = 1'b1;
                                state_next     = ST_EMIT_RD;
                            end else if (sts.is_start) begin
                                cmd.out_start = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
                if (sts.slot_free) begin
                    cmd.out_data  = 1'b1;
                    cmd.emit_step = 1'b1;
                    state_next    = sts.emit_last ? ST_BYPASS : ST_EMIT_RD;
                end
            end
            ST_HALT: begin
                state_next = ST_HALT;
            end
            default: begin
                state_next = ST_START;
            end
        endcase
    end

endmodule

// ----- rtl/srec_dp.sv -----
// ----------------------------------------------------------------------------
// srec_dp: S-record datapath
// Hex decode, checksum, address assembly, data byte buffer, output register.
// ----------------------------------------------------------------------------
module srec_dp
    import srec_pkg::*;
#(
    parameter int MAX_RECORD_CHARS = MAX_RECORD_CHARS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic [7:0]  s_in_char,
    input  srec_cmd_t   cmd,
    output srec_sts_t   sts,
    input  logic        m_ready,
    output logic        m_valid,
    output logic [1:0]  m_kind,
    output logic [31:0] m_target_address,
    output logic [7:0]  m_data_byte,
    output logic        m_last
);

    localparam int DEPTH = MAX_RECORD_CHARS / 2;
    localparam int DW    = $clog2(DEPTH);

    logic [31:0] base_reg;
    logic [7:0]  min_reg;
    logic [7:0]  type_reg;
    logic [7:0]  char_count_reg;
    logic [3:0]  hi_nib_reg;
    logic [7:0]  count_reg;
    logic [7:0]  sum_reg;
    logic [31:0] addr_reg;
    logic [31:0] emit_base_reg;
    logic [DW-1:0] emit_idx_reg;
    logic [7:0]  rd_data_reg;
    logic [7:0]  mem [DEPTH];

    logic        m_valid_reg;
    logic [1:0]  m_kind_reg;
    logic [31:0] m_addr_reg;
    logic [7:0]  m_data_reg;
    logic        m_last_reg;

    logic [3:0]  nib;
    logic [7:0]  cur_byte;
    logic [2:0]  nab;
    logic [7:0]  nab8;
    logic [7:0]  k;
    logic [7:0]  wr_idx;
    logic [7:0]  ndata;
    logic        is_digit;

    assign nib      = hex_val(s_in_char);
    assign cur_byte = {hi_nib_reg, nib};
    assign nab      = addr_bytes(type_reg);
    assign nab8     = {5'd0, nab};
    assign k        = {1'b0, char_count_reg[7:1]} - 8'd1;
    assign wr_idx   = k - 8'd1 - nab8;
    assign ndata    = count_reg - 8'd1 - nab8;
    assign is_digit = (s_in_char >= CH_0) && (s_in_char <= CH_9);

    always_comb begin
        sts.c_is_s       = (s_in_char == CH_S);
        sts.c_is_nl      = (s_in_char == CH_NL);
        sts.c_is_digit   = is_digit;
        sts.c_is_4       = (s_in_char == CH_4);
        sts.c_is_hex     = is_digit || ((s_in_char >= CH_A) && (s_in_char <= CH_F));
        sts.second_digit = char_count_reg[0];
        sts.cnt_bad      = (cur_byte < min_reg) || (cur_byte < (nab8 + 8'd1));
        sts.full         = ({1'b0, char_count_reg} >= 9'(MAX_RECORD_CHARS));
        sts.done         = ({1'b0, char_count_reg} == (9'd3 + {count_reg, 1'b0}));
        sts.sum_ok       = (~sum_reg == cur_byte);
        sts.is_data      = (type_reg == CH_1) || (type_reg == CH_2) || (type_reg == CH_3);
        sts.is_start     = (type_reg == CH_7) || (type_reg == CH_8) || (type_reg == CH_9);
        sts.ndata_zero   = (ndata == 8'd0);
        sts.emit_last    = ({{(8-DW){1'b0}}, emit_idx_reg} == (ndata - 8'd1));
        sts.slot_free    = !m_valid_reg || m_ready;
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= 32'd0;
            min_reg  <= 8'd3;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_BASE_ADDRESS:   base_reg <= cfg_data;
                CFG_MIN_BYTE_COUNT: min_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // parse registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_count_reg <= 8'd0;
            count_reg      <= 8'd0;
            emit_idx_reg   <= '0;
        end else begin
            if (cmd.rec_start) begin
                char_count_reg <= 8'd1;
                addr_reg       <= 32'd0;
            end
            if (cmd.load_type) begin
                type_reg       <= s_in_char;
                char_count_reg <= 8'd2;
            end
            if (cmd.count_char) begin
                char_count_reg <= char_count_reg + 8'd1;
                hi_nib_reg     <= nib;
                if (char_count_reg[0]) begin
                    count_reg <= cur_byte;
                    sum_reg   <= cur_byte;
                end
            end
            if (cmd.body_char) begin
                char_count_reg <= char_count_reg + 8'd1;
                hi_nib_reg     <= nib;
                if (char_count_reg[0] && (k < count_reg)) begin
                    sum_reg <= sum_reg + cur_byte;
                    if (k <= nab8) addr_reg <= {addr_reg[23:0], cur_byte};
                end
            end
            if (cmd.start_emit) begin
                emit_base_reg <= base_reg + addr_reg;
                emit_idx_reg  <= '0;
            end
            if (cmd.emit_step) emit_idx_reg <= emit_idx_reg + 1'b1;
        end
    end

    // data byte buffer
    always_ff @(posedge aclk) begin
        if (cmd.body_char && char_count_reg[0] && (k < count_reg) && (k > nab8)) begin
            mem[wr_idx[DW-1:0]] <= cur_byte;
        end
        rd_data_reg <= mem[emit_idx_reg];
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready) m_valid_reg <= 1'b0;
            if (cmd.out_err || cmd.out_start || cmd.out_data) m_valid_reg <= 1'b1;
        end
        if (cmd.out_err) begin
            m_kind_reg <= KIND_ERROR;
            m_addr_reg <= 32'd0;
            m_data_reg <= 8'd0;
            m_last_reg <= 1'b1;
        end else if (cmd.out_start) begin
            m_kind_reg <= KIND_START;
            m_addr_reg <= base_reg + addr_reg;
            m_data_reg <= 8'd0;
            m_last_reg <= 1'b1;
        end else if (cmd.out_data) begin
            m_kind_reg <= KIND_WRITE;
            m_addr_reg <= emit_base_reg + {{(32-DW){1'b0}}, emit_idx_reg};
            m_data_reg <= rd_data_reg;
            m_last_reg <= sts.emit_last;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = m_kind_reg;
    assign m_target_address = m_addr_reg;
    assign m_data_byte      = m_data_reg;
    assign m_last           = m_last_reg;

endmodule

// ----- rtl/srec_record_loader_top.sv -----
// ----------------------------------------------------------------------------
// srec_record_loader_top: Motorola S-record loader
// One ASCII character per input word; emits byte writes, start address, error.
// ----------------------------------------------------------------------------
// Timing: a result word (error, start address) is registered into the output
//   register as its character is taken; each data byte after the checksum
//   character takes a buffer read, then an output load when the slot is free.
// Throughput: one character per cycle while parsing and the output slot is
//   free; write-out adds a read on the single read port and an output load.
// Reset: synchronous, active low; parser returns to start of line, halt
//   clears, base_address = 0, min_byte_count = 3. Byte buffer is not cleared.
module srec_record_loader_top
    import srec_pkg::*;
#(
    parameter int MAX_RECORD_CHARS = MAX_RECORD_CHARS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_char,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [31:0] m_target_address,
    output logic [7:0]  m_data_byte,
    output logic        m_last
);

    srec_cmd_t  cmd;
    srec_sts_t  sts;
    ctl_state_t state;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    srec_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd),
        .state   (state)
    );

    srec_dp #(
        .MAX_RECORD_CHARS (MAX_RECORD_CHARS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_in_char        (s_in_char),
        .cmd              (cmd),
        .sts              (sts),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_kind           (m_kind),
        .m_target_address (m_target_address),
        .m_data_byte      (m_data_byte),
        .m_last           (m_last)
    );

    // at most one kind of result loaded per cycle
    a_one_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.out_err, cmd.out_start, cmd.out_data}))
        else $error("multiple output loads");

    // a load never overwrites a word still waiting
    a_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_err || cmd.out_start || cmd.out_data) |-> (!m_valid || m_ready))
        else $error("output word overwritten");

    // halt is sticky
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (state == ST_HALT) |=> (state == ST_HALT))
        else $error("left halt");

    // error word is a lone, final word with zero payload
    a_err_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_ERROR) |-> (m_last && m_target_address == 32'd0))
        else $error("bad error word");

endmodule

// ----- dv/srec_record_loader_top_tb.sv -----
// ----------------------------------------------------------------------------
// srec_record_loader_top_tb: self-checking bench for the S-record loader
// Streams S-record text one character per word, predicts the write, start
// and error words in a local parser model, and checks them in order.
// ----------------------------------------------------------------------------
module srec_record_loader_top_tb
    import srec_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_CHARS  = 80;
    localparam int IDLE_PCT   = 11;
    localparam int STALL_LIMIT = 5000;

    // parser phases of the predictor
    typedef enum logic [2:0] {
        PH_LINE_START, PH_SKIP_LINE, PH_TYPE_CHAR, PH_COUNT_CHARS, PH_BODY_CHARS
    } parse_phase_t;

    // fault flavors for the closing test (the block halts after one)
    typedef enum int {
        FLT_BAD_TYPE, FLT_LOWER_HEX, FLT_MIN_COUNT, FLT_LONG_RECORD,
        FLT_BAD_SUM, FLT_ZERO_COUNT
    } fault_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] target_address;
        logic [7:0]  data_byte;
        logic        last;
    } loader_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_BASE_ADDRESS;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_char = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [31:0] m_target_address;
    logic [7:0]  m_data_byte;
    logic        m_last;

    srec_record_loader_top u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_in_char        (s_in_char),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_target_address (m_target_address),
        .m_data_byte      (m_data_byte),
        .m_last           (m_last)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the parser and its registers
    // ------------------------------------------------------------------
    parse_phase_t phase;
    logic [7:0]   rec_chars [BUF_CHARS];
    int unsigned  char_cnt;
    int unsigned  byte_cnt;
    bit           halted;
    logic [31:0]  base_addr;
    logic [7:0]   min_count;

    loader_word_t expected_words[$];
    int           fail_count = 0;
    bit           quiet = 1'b0;      // suppress random idling on both sides
    int           rx_hold = 0;       // receiver hold-off request, in cycles
    logic [7:0]   line_chars[$];     // text of the line under construction

    function automatic bit is_hex(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] nib(logic [7:0] c);
        if (c >= "0" && c <= "9") return 4'(c - "0");
        if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
        return 4'd0;
    endfunction

    function automatic logic [7:0] buf_byte(int unsigned pos);
        if (pos + 1 >= BUF_CHARS) return 8'd0;
        return {nib(rec_chars[pos]), nib(rec_chars[pos + 1])};
    endfunction

    function automatic int unsigned width_of(logic [7:0] t);
        if (t == CH_1 || t == CH_9) return 2;
        if (t == CH_2 || t == CH_8) return 3;
        if (t == CH_3 || t == CH_7) return 4;
        return 0;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v);
        return (v < 10) ? 8'("0" + v) : 8'("A" + v - 10);
    endfunction

    task automatic push_word(logic [1:0] k, logic [31:0] a, logic [7:0] d, logic l);
        loader_word_t w;
        w.kind = k; w.target_address = a; w.data_byte = d; w.last = l;
        expected_words.push_back(w);
    endtask

    task automatic flag_fault();
        halted = 1'b1;
        push_word(KIND_ERROR, 32'd0, 8'd0, 1'b1);
    endtask

    // checksum (fault on mismatch), then emit writes or start address
    task automatic close_record();
        logic [7:0]  sum;
        logic [31:0] addr;
        logic [7:0]  rtype;
        int unsigned nab, ndata;
        sum = 8'd0;
        addr = 32'd0;
        rtype = rec_chars[1];
        for (int i = 0; i < byte_cnt; i++) sum += buf_byte(2 + 2 * i);
        if (8'hFF - sum != buf_byte(2 + 2 * byte_cnt)) begin
            flag_fault();
            return;
        end
        phase = PH_SKIP_LINE;
        nab = width_of(rtype);
        for (int i = 0; i < nab; i++) addr = {addr[23:0], buf_byte(4 + 2 * i)};
        if (rtype == CH_1 || rtype == CH_2 || rtype == CH_3) begin
            ndata = byte_cnt - 1 - nab;
            for (int i = 0; i < ndata; i++)
                push_word(KIND_WRITE, base_addr + addr + i,
                          buf_byte(4 + 2 * nab + 2 * i), i + 1 == ndata);
        end else if (nab != 0) begin
            push_word(KIND_START, base_addr + addr, 8'd0, 1'b1);
        end
    endtask

    // one accepted character through the parser
    task automatic parse_char(logic [7:0] c);
        if (halted) return;
        case (phase)
            PH_LINE_START: begin
                if (c == CH_S) begin
                    rec_chars[0] = c;
                    char_cnt = 1;
                    phase = PH_TYPE_CHAR;
                end else if (c != CH_NL) begin
                    phase = PH_SKIP_LINE;
                end
            end
            PH_SKIP_LINE: begin
                if (c == CH_NL) phase = PH_LINE_START;
            end
            PH_TYPE_CHAR: begin
                if (c < CH_0 || c > CH_9) begin
                    flag_fault();
                end else begin
                    rec_chars[1] = c;
                    char_cnt = 2;
                    phase = (c == CH_4) ? PH_SKIP_LINE : PH_COUNT_CHARS;
                end
            end
            PH_COUNT_CHARS: begin
                if (!is_hex(c)) begin
                    flag_fault();
                end else begin
                    rec_chars[char_cnt] = c;
                    char_cnt++;
                    if (char_cnt == 4) begin
                        byte_cnt = buf_byte(2);
                        if (byte_cnt < min_count || byte_cnt < width_of(rec_chars[1]) + 1)
                            flag_fault();
                        else
                            phase = PH_BODY_CHARS;
                    end
                end
            end
            default: begin
                if (!is_hex(c) || char_cnt >= BUF_CHARS) begin
                    flag_fault();
                end else begin
                    rec_chars[char_cnt] = c;
                    char_cnt++;
                    if (char_cnt == 4 + 2 * byte_cnt) close_record();
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // one character word; valid stays high between back-to-back words
    task automatic send_char(logic [7:0] c);
        if (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_char <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        parse_char(c);
        @(negedge aclk);
    endtask

    task automatic send_line();
        foreach (line_chars[i]) send_char(line_chars[i]);
        line_chars.delete();
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge aclk);
        // a record close may still be walking the buffer
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_BASE_ADDRESS) base_addr = val;
        else min_count = val[7:0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_hex_byte(logic [7:0] b);
        line_chars.push_back(hex_char(b[7:4]));
        line_chars.push_back(hex_char(b[3:0]));
    endfunction

    // builds "S<type><count><payload><checksum>", payload = address + data
    function automatic void build_record(logic [7:0] rtype, logic [7:0] payload[$],
                                         bit corrupt_sum);
        logic [7:0] sum;
        sum = 8'(payload.size() + 1);
        line_chars.push_back(CH_S);
        line_chars.push_back(rtype);
        add_hex_byte(sum);
        foreach (payload[i]) begin
            add_hex_byte(payload[i]);
            sum += payload[i];
        end
        add_hex_byte(corrupt_sum ? sum : ~sum);
    endfunction

    // well-formed record with random content, honoring the current minimum
    task automatic send_random_record(logic [7:0] rtype, int ndata);
        logic [7:0] payload[$];
        int nab;
        nab = width_of(rtype);
        if (nab == 0) nab = 2;   // S0/S5/S6 still carry an address field
        if (rtype == CH_7 || rtype == CH_8 || rtype == CH_9) ndata = 0;
        if (nab + 1 + ndata < min_count) ndata = min_count - nab - 1;
        if (nab + 1 + ndata > 38) ndata = 37 - nab;
        repeat (nab + ndata) payload.push_back(8'($urandom));
        build_record(rtype, payload, 1'b0);
        // junk after the checksum is ignored up to the newline
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(4, 1)) line_chars.push_back(8'($urandom_range(8'h7E, 8'h20)));
        line_chars.push_back(CH_NL);
        send_line();
    endtask

    task automatic send_noise_line();
        logic [7:0] c;
        c = 8'($urandom);
        while (c == CH_S || c == CH_NL) c = 8'($urandom);
        line_chars.push_back(c);
        repeat ($urandom_range(12)) begin
            c = 8'($urandom);
            if (c == CH_NL) c = 8'hFF;
            line_chars.push_back(c);
        end
        line_chars.push_back(CH_NL);
        send_line();
    endtask

    function automatic logic [7:0] pick_type();
        logic [7:0] types[9] = '{CH_0, CH_1, CH_2, CH_3, 8'h35, 8'h36, CH_7, CH_8, CH_9};
        return types[$urandom_range(8)];
    endfunction

    // ------------------------------------------------------------------
    // Receiver, checker, watchdog
    // ------------------------------------------------------------------
    int hold_left = 0;
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            hold_left = rx_hold;
            rx_hold = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        loader_word_t w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word kind", 32'(m_kind), 32'd0);
            end else begin
                w = expected_words.pop_front();
                if (m_kind !== w.kind)
                    report_mismatch("kind", 32'(m_kind), 32'(w.kind));
                if (m_target_address !== w.target_address)
                    report_mismatch("address", m_target_address, w.target_address);
                if (m_data_byte !== w.data_byte)
                    report_mismatch("data", 32'(m_data_byte), 32'(w.data_byte));
                if (m_last !== w.last)
                    report_mismatch("last", 32'(m_last), 32'(w.last));
            end
        end
    end

    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        logic [7:0] p[$];
        line_chars.push_back(CH_NL);                         // empty line
        send_line();
        send_noise_line();                                   // not an S line
        line_chars = '{CH_S, CH_4, "0", "5", "Z", "z", CH_NL}; // S4 is skipped
        send_line();
        p = '{8'h00, 8'h00, 8'h41};
        build_record(CH_0, p, 0); line_chars.push_back(CH_NL); send_line();
        p = '{8'h12, 8'h34};                                 // S1, no data
        build_record(CH_1, p, 0); line_chars.push_back(CH_NL); send_line();
        p = '{8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hA5};            // address runs past 0xFFFF
        build_record(CH_1, p, 0); line_chars.push_back(CH_NL); send_line();
        p = '{8'h80, 8'h00, 8'h01, 8'h5A};
        build_record(CH_2, p, 0); line_chars.push_back(CH_NL); send_line();
        p = '{8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'h01, 8'h02, 8'h03};
        build_record(CH_3, p, 0); line_chars.push_back(CH_NL); send_line();
        p = '{8'h00, 8'h03};
        build_record(8'h35, p, 0); line_chars.push_back(CH_NL); send_line();
        build_record(8'h36, p, 0); line_chars.push_back(CH_NL); send_line();
        p = '{8'hDE, 8'hAD, 8'hBE, 8'hEF};
        build_record(CH_7, p, 0); line_chars.push_back(CH_NL); send_line();
        p = '{8'h01, 8'h23, 8'h45};
        build_record(CH_8, p, 0); line_chars.push_back(CH_NL); send_line();
        p = '{8'hFF, 8'hFF};
        build_record(CH_9, p, 0);
        line_chars.push_back("x"); line_chars.push_back(CH_NL);  // trailing junk
        send_line();
        send_random_record(CH_1, 37);                        // longest record
    endtask

    task automatic test_config();
        write_reg(CFG_BASE_ADDRESS, 32'hFFFF_FFFF);
        write_reg(CFG_MIN_BYTE_COUNT, 32'd0);
        send_random_record(CH_0, 0);
        send_random_record(CH_3, 3);
        send_random_record(CH_9, 0);
        write_reg(CFG_BASE_ADDRESS, $urandom);
        write_reg(CFG_MIN_BYTE_COUNT, 32'($urandom_range(10, 4)));
        send_random_record(CH_2, 1);
        send_random_record(CH_7, 0);
        write_reg(CFG_MIN_BYTE_COUNT, 32'd3);
        write_reg(CFG_BASE_ADDRESS, 32'd0);
    endtask

    task automatic test_random_stream();
        int sent, r;
        sent = 0;
        quiet = 1'b1;   // first stretch runs without any idling
        while (sent < 70) begin
            if (sent > 35) quiet = 1'b0;
            r = $urandom_range(99);
            if (r < 80) begin
                send_random_record(pick_type(),
                    ($urandom_range(9) == 0) ? $urandom_range(37) : $urandom_range(8));
                sent += 20;
            end else if (r < 90) begin
                send_noise_line();
                sent += 6;
            end else begin
                line_chars = '{CH_NL};
                if (r < 95) line_chars = '{CH_S, CH_4, hex_char(4'($urandom)), CH_NL};
                send_line();
                sent += 2;
            end
        end
        quiet = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering, so the block backs up
    task automatic test_backpressure();
        rx_hold = 400;
        repeat (2) send_random_record(CH_3, 6);
        // pause until all words have come, then resume
        wait_drained();
        send_random_record(CH_1, 5);
    endtask

    // one fault halts the block for the rest of the run
    task automatic test_fault();
        fault_t f;
        logic [7:0] p[$];
        f = fault_t'($urandom_range(FLT_ZERO_COUNT));
        case (f)
            FLT_BAD_TYPE:  line_chars = '{CH_S, "X"};
            FLT_LOWER_HEX: line_chars = '{CH_S, CH_1, "0", "5", "1", "a"};
            FLT_MIN_COUNT: begin
                write_reg(CFG_MIN_BYTE_COUNT, 32'hFF);
                line_chars = '{CH_S, CH_1, "F", "E"};
            end
            FLT_LONG_RECORD: begin
                line_chars = '{CH_S, CH_1, "4", "0"};
                repeat (80) line_chars.push_back(hex_char(4'($urandom)));
            end
            FLT_BAD_SUM: begin
                p = '{8'h10, 8'h00, 8'h77};
                build_record(CH_1, p, 1);
            end
            default:       line_chars = '{CH_S, CH_0, "0", "0"};
        endcase
        send_line();
        repeat (20) send_char(8'($urandom));   // all ignored once halted
        p = '{8'h00, 8'h00, 8'h11};
        build_record(CH_1, p, 0); line_chars.push_back(CH_NL); send_line();
    endtask

    initial begin
        phase = PH_LINE_START;
        char_cnt = 0;
        byte_cnt = 0;
        halted = 1'b0;
        base_addr = 32'd0;
        min_count = 8'd3;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_config();
        test_random_stream();
        test_backpressure();
        test_fault();
        wait_drained();
        if (fail_count == 0 && expected_words.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/srec_pkg.sv
rtl/srec_ctrl.sv
rtl/srec_dp.sv
rtl/srec_record_loader_top.sv
dv/srec_record_loader_top_tb.sv
